// ===== hw/rtl/lms_pkg.sv =====
package lms_pkg;

    localparam int REG_W       = 31;
    localparam int IDX_W       = 17;
    localparam int SUM_W       = 53;
    localparam int DIV_W       = 32;
    localparam int NUM_W       = 63;
    localparam int PROD_W      = 62;
    localparam int CNT_W       = 6;
    localparam int MAX_LEN_DEF = 65536;
    localparam int CMD_DEPTH   = 2;

    typedef enum logic [1:0] {
        REG_LCG_MULTIPLIER = 2'd0,
        REG_LCG_INCREMENT  = 2'd1,
        REG_LCG_MODULUS    = 2'd2,
        REG_VALUE_RANGE    = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_MUL,
        S_LCG_START,
        S_LCG,
        S_DONE
    } engine_state_t;

    // Generator settings as the search engine sees them; zero divisors
    // already stand for 2^31.
    typedef struct packed {
        logic [REG_W-1:0] mult;
        logic [REG_W-1:0] incr;
        logic [DIV_W-1:0] mod_div;
        logic [DIV_W-1:0] range_div;
        logic [REG_W-1:0] half;
    } lcg_cfg_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [CNT_W-1:0] nbits;
        logic [DIV_W-1:0] div;
    } mod_req_t;

endpackage

// ===== hw/rtl/lms_front.sv =====
module lms_front #(
    parameter int MAX_LEN = lms_pkg::MAX_LEN_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [lms_pkg::IDX_W-1:0] seq_count,
    output logic                     cmd_valid,
    output logic [lms_pkg::IDX_W-1:0] cmd_n,
    input  logic                     cmd_pop
);
    import lms_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);

    logic [IDX_W-1:0] slot_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic [IDX_W-1:0] n_clipped;
    logic             do_push;
    logic             do_pop;

    // Lengths above the supported maximum are clipped before queuing.
    always_comb
    begin
        if (32'(seq_count) > 32'(MAX_LEN))
        begin
            n_clipped = IDX_W'(MAX_LEN);
        end
        else
        begin
            n_clipped = seq_count;
        end
    end

    assign full      = (count_reg == (PTR_W+1)'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd_n     = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= n_clipped;
        end
    end

endmodule

// ===== hw/rtl/lms_mod_unit.sv =====
module lms_mod_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lms_pkg::mod_req_t         req,
    output logic                      done,
    output logic [lms_pkg::REG_W-1:0] rem
);
    import lms_pkg::*;

    logic [NUM_W-1:0] num_reg, num_next;
    logic [REG_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] trial;

    // Restoring remainder, one dividend bit per cycle, MSB first.
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign done  = (cnt_reg == '0);
    assign rem   = rem_reg;

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        if (req.start)
        begin
            num_next = req.num;
            rem_next = '0;
            div_next = req.div;
            cnt_next = req.nbits;
        end
        else if (cnt_reg != '0)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (trial >= div_reg)
            begin
                rem_next = REG_W'(trial - div_reg);
            end
            else
            begin
                rem_next = REG_W'(trial);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule

// ===== hw/rtl/lms_engine.sv =====
module lms_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lms_pkg::lcg_cfg_t         cfg,
    input  logic                      cmd_valid,
    input  logic [lms_pkg::IDX_W-1:0] cmd_n,
    output logic                      cmd_pop,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [lms_pkg::SUM_W-1:0] best_sum,
    output logic signed [lms_pkg::IDX_W-1:0] start_before,
    output logic [lms_pkg::IDX_W-1:0] end_index
);
    import lms_pkg::*;

    engine_state_t state_reg, state_next;

    logic [REG_W-1:0]        y_reg, y_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [IDX_W-1:0]        n_reg, n_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [SUM_W-1:0] ending_reg, ending_next;
    logic [IDX_W-1:0]        estart_reg, estart_next;
    logic signed [SUM_W-1:0] top_reg, top_next;
    logic [IDX_W-1:0]        tstart_reg, tstart_next;
    logic [IDX_W-1:0]        tend_reg, tend_next;

    logic                    res_valid_reg, res_valid_next;
    logic signed [SUM_W-1:0] res_sum_reg, res_sum_next;
    logic [IDX_W-1:0]        res_start_reg, res_start_next;
    logic [IDX_W-1:0]        res_end_reg, res_end_next;

    mod_req_t                mreq;
    logic                    mdone;
    logic [REG_W-1:0]        mrem;

    logic [REG_W+1:0]        x_short;
    logic signed [SUM_W-1:0] x_val;
    logic signed [SUM_W-1:0] cand_sum;
    logic [IDX_W-1:0]        cand_start;

    lms_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .done  (mdone),
        .rem   (mrem)
    );

    // Mapped value and the Kadane candidate for the current position.
    assign x_short = {2'b00, mrem} - {2'b00, cfg.half};
    assign x_val   = SUM_W'(signed'(x_short));

    always_comb
    begin
        if (!ending_reg[SUM_W-1])
        begin
            cand_sum   = ending_reg + x_val;
            cand_start = estart_reg;
        end
        else
        begin
            cand_sum   = x_val;
            cand_start = pos_reg;
        end
    end

    assign empty        = !res_valid_reg;
    assign best_sum     = res_sum_reg;
    assign start_before = signed'(res_start_reg);
    assign end_index    = res_end_reg;

    always_comb
    begin
        state_next     = state_reg;
        y_next         = y_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        prod_next      = prod_reg;
        ending_next    = ending_reg;
        estart_next    = estart_reg;
        top_next       = top_reg;
        tstart_next    = tstart_reg;
        tend_next      = tend_reg;
        res_valid_next = res_valid_reg;
        res_sum_next   = res_sum_reg;
        res_start_next = res_start_reg;
        res_end_next   = res_end_reg;
        cmd_pop        = 1'b0;
        mreq.start     = 1'b0;
        mreq.num       = {y_reg, (NUM_W-REG_W)'(0)};
        mreq.nbits     = CNT_W'(REG_W);
        mreq.div       = cfg.range_div;

        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    n_next     = cmd_n;
                    y_next     = REG_W'(1);
                    pos_next   = '0;
                    mreq.start = 1'b1;
                    mreq.num   = {REG_W'(1), (NUM_W-REG_W)'(0)};
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                if (mdone)
                begin
                    if (pos_reg == '0)
                    begin
                        ending_next = x_val;
                        estart_next = '0;
                        top_next    = x_val;
                        tstart_next = '0;
                        tend_next   = '0;
                    end
                    else
                    begin
                        ending_next = cand_sum;
                        estart_next = cand_start;
                        if (cand_sum > top_reg)
                        begin
                            top_next    = cand_sum;
                            tstart_next = cand_start;
                            tend_next   = pos_reg;
                        end
                    end
                    state_next = (pos_reg == n_reg) ? S_DONE : S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = cfg.mult * y_reg;
                state_next = S_LCG_START;
            end
            S_LCG_START:
            begin
                mreq.start = 1'b1;
                mreq.num   = NUM_W'(prod_reg) + NUM_W'(cfg.incr);
                mreq.nbits = CNT_W'(NUM_W);
                mreq.div   = cfg.mod_div;
                state_next = S_LCG;
            end
            S_LCG:
            begin
                if (mdone)
                begin
                    y_next     = mrem;
                    pos_next   = pos_reg + 1'b1;
                    mreq.start = 1'b1;
                    mreq.num   = {mrem, (NUM_W-REG_W)'(0)};
                    state_next = S_MAP;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg)
                begin
                    res_valid_next = 1'b1;
                    res_sum_next   = top_reg;
                    res_start_next = tstart_reg - 1'b1;
                    res_end_next   = tend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg         <= y_next;
        pos_reg       <= pos_next;
        n_reg         <= n_next;
        prod_reg      <= prod_next;
        ending_reg    <= ending_next;
        estart_reg    <= estart_next;
        top_reg       <= top_next;
        tstart_reg    <= tstart_next;
        tend_reg      <= tend_next;
        res_sum_reg   <= res_sum_next;
        res_start_reg <= res_start_next;
        res_end_reg   <= res_end_next;
    end

endmodule

// ===== hw/rtl/lcg_max_subarray_search.sv =====
// Maximum-sum contiguous subarray search over a generated sequence. Each request
// carries a length n (clipped to MAX_LEN); the block generates y0 = 1 and
// y_i = (a*y_(i-1) + b) mod c for i = 1..n, maps each to x_i = (y_i mod d) - d/2,
// and runs a Kadane search over x_0..x_n in which a run whose sum is not negative
// is extended and the first strict maximum wins. The result gives the best sum,
// the start index of the best run minus one (-1 when it starts at zero) and its
// end index. A zero modulus or range register acts as 2^31. One request is in
// the search at a time: each value is reduced mod d, then multiplied by a in the
// 31x31 multiplier, offset by b and reduced mod c, with both remainders taken by
// the shared one-bit-per-cycle remainder unit.
// A two-entry request queue in front and a one-entry result register behind
// let the host queue the next request and drain the last result independently.
// Registers are written through cfg_write/cfg_index/cfg_data and must only be
// changed while no request is outstanding.
module lcg_max_subarray_search #(
    parameter int MAX_LEN = lms_pkg::MAX_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  lms_pkg::cfg_reg_t         cfg_index,
    input  logic [lms_pkg::REG_W-1:0] cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic [lms_pkg::IDX_W-1:0] seq_count,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [lms_pkg::SUM_W-1:0] best_sum,
    output logic signed [lms_pkg::IDX_W-1:0] start_before,
    output logic [lms_pkg::IDX_W-1:0] end_index
);
    import lms_pkg::*;

    logic [REG_W-1:0] mult_reg;
    logic [REG_W-1:0] incr_reg;
    logic [REG_W-1:0] modulus_reg;
    logic [REG_W-1:0] range_reg;
    lcg_cfg_t         cfg;
    logic             cmd_valid;
    logic [IDX_W-1:0] cmd_n;
    logic             cmd_pop;

    // Configuration registers; reset values follow the register map.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg    <= '0;
            incr_reg    <= '0;
            modulus_reg <= REG_W'(1);
            range_reg   <= REG_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LCG_MULTIPLIER: mult_reg    <= cfg_data;
                REG_LCG_INCREMENT:  incr_reg    <= cfg_data;
                REG_LCG_MODULUS:    modulus_reg <= cfg_data;
                REG_VALUE_RANGE:    range_reg   <= cfg_data;
                default:            mult_reg    <= mult_reg;
            endcase
        end
    end

    // A zero divisor means 2^31, which the 32-bit divisor path holds directly.
    always_comb
    begin
        cfg.mult      = mult_reg;
        cfg.incr      = incr_reg;
        cfg.mod_div   = (modulus_reg == '0) ? (DIV_W'(1) << REG_W) : DIV_W'(modulus_reg);
        cfg.range_div = (range_reg == '0) ? (DIV_W'(1) << REG_W) : DIV_W'(range_reg);
        cfg.half      = (range_reg == '0) ? (REG_W'(1) << (REG_W - 1)) : (range_reg >> 1);
    end

    lms_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .seq_count (seq_count),
        .cmd_valid (cmd_valid),
        .cmd_n     (cmd_n),
        .cmd_pop   (cmd_pop)
    );

    lms_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd_valid    (cmd_valid),
        .cmd_n        (cmd_n),
        .cmd_pop      (cmd_pop),
        .empty        (empty),
        .pop          (pop),
        .best_sum     (best_sum),
        .start_before (start_before),
        .end_index    (end_index)
    );

endmodule

// ===== hw/rtl/lms_checker.sv =====
module lms_checker #(
    parameter int MAX_LEN = lms_pkg::MAX_LEN_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      push,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic signed [lms_pkg::SUM_W-1:0] best_sum,
    input logic signed [lms_pkg::IDX_W-1:0] start_before,
    input logic [lms_pkg::IDX_W-1:0] end_index
);
    import lms_pkg::*;

    localparam int END_MAX = (MAX_LEN < (1 << IDX_W) - 1) ? MAX_LEN : (1 << IDX_W) - 1;

    // Each result must have been caused by an accepted request.
    logic [2:0] open_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + 3'((push && !full) ? 1 : 0)
                                 - 3'((pop && !empty) ? 1 : 0);
        end
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(best_sum) && $stable(start_before)
                              && $stable(end_index)))
        else $error("result changed while waiting");

    a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (IDX_W'(start_before + IDX_W'(1)) <= end_index))
        else $error("best run starts after it ends");

    a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(end_index) <= END_MAX))
        else $error("end index beyond maximum length");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (open_reg != '0))
        else $error("result without an outstanding request");

endmodule

bind lcg_max_subarray_search lms_checker #(.MAX_LEN(MAX_LEN)) u_lms_checker (.*);
